// ===== sv/crt_pkg.sv =====
`timescale 1ns / 1ps

package crt_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRESH_LIMIT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESP_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_CODE = 2'd2;

    localparam logic [31:0] FRESH_LIMIT_RST  = 32'd1000;
    localparam logic [31:0] RESP_TIMEOUT_RST = 32'd500;
    localparam logic [7:0]  TIMEOUT_CODE_RST = 8'd1;

    localparam logic [2:0] KIND_REQUEST = 3'd0;
    localparam logic [2:0] KIND_SAMPLE  = 3'd1;
    localparam logic [2:0] KIND_TICK    = 3'd2;
    localparam logic [2:0] KIND_DONE    = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;

    localparam logic [1:0] DEC_BUSY    = 2'd0;
    localparam logic [1:0] DEC_PENDING = 2'd1;
    localparam logic [1:0] DEC_CACHE   = 2'd2;
    localparam logic [1:0] DEC_REMOTE  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_REPLY = 2'd2,
        PH_ERROR = 2'd3
    } phase_t;

endpackage

// ===== sv/cached_request_tracker.sv =====
`timescale 1ns / 1ps
// A request accepted is held in stage 1 while the cache memory is read at the accept
// edge, then moves on to the output register once the output stage is free.
// One request per cycle while the output is not stalled; the cache memory has one write and one read
// port, and a write and read of the same entry in one cycle is forwarded.
// Reset (aresetn low, synchronous): phase idle, all state and ages zero, config
// registers to their defaults, every cache entry marked unwritten (reads as zero).
module cached_request_tracker
    import crt_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // flow_id[15:0], fetch_mode[16], sample_value[32:17], channel[35:33], zero fill
    input  logic [39:0]            s_tdata,
    // kind[2:0]
    input  logic [2:0]             s_tuser,
    // last_sample
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // decision[1:0], accepted[2], phase[4:3], pending_flow[20:5],
    // fault_code[28:21], cache_value[44:29], zero fill
    output logic [47:0]            m_tdata
);

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // input fields
    logic [15:0]       in_flow;
    logic              in_mode;
    logic [15:0]       in_sample;
    logic [2:0]        in_chan;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;

    assign in_flow   = s_tdata[15:0];
    assign in_mode   = s_tdata[16];
    assign in_sample = s_tdata[32:17];
    assign in_chan   = s_tdata[35:33];
    assign in_addr   = ADDR_W'(in_chan);
    assign in_range  = (32'(in_chan) < NUM_CHANNELS);

    // config
    logic [31:0] fresh_limit_reg;
    logic [31:0] resp_timeout_reg;
    logic [7:0]  timeout_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_limit_reg  <= FRESH_LIMIT_RST;
            resp_timeout_reg <= RESP_TIMEOUT_RST;
            timeout_code_reg <= TIMEOUT_CODE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRESH_LIMIT:  fresh_limit_reg  <= cfg_wdata;
                CFG_RESP_TIMEOUT: resp_timeout_reg <= cfg_wdata;
                CFG_TIMEOUT_CODE: timeout_code_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // handshake and pipeline control
    logic st1_valid_reg;
    logic m_tvalid_reg;
    logic st1_adv;
    logic accept;

    assign st1_adv  = st1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !st1_valid_reg || st1_adv;
    assign accept   = s_tvalid && s_tready;

    // tracker state; ages are counters advanced on each tick
    phase_t      phase_reg, phase_next;
    logic [15:0] flow_reg, flow_next;
    logic [7:0]  error_reg, error_next;
    logic [31:0] wait_age_reg, wait_age_next;
    logic [31:0] cache_age_reg, cache_age_next;
    logic        cache_valid_reg, cache_valid_next;
    logic [1:0]  decision;
    logic        accepted;
    logic        mem_wr;
    logic [31:0] wait_age_inc;

    assign wait_age_inc = wait_age_reg + 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            flow_reg        <= '0;
            error_reg       <= '0;
            wait_age_reg    <= '0;
            cache_age_reg   <= '0;
            cache_valid_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            flow_reg        <= flow_next;
            error_reg       <= error_next;
            wait_age_reg    <= wait_age_next;
            cache_age_reg   <= cache_age_next;
            cache_valid_reg <= cache_valid_next;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        flow_next        = flow_reg;
        error_next       = error_reg;
        wait_age_next    = wait_age_reg;
        cache_age_next   = cache_age_reg;
        cache_valid_next = cache_valid_reg;
        decision         = DEC_BUSY;
        accepted         = 1'b0;
        mem_wr           = 1'b0;
        if (accept) begin
            case (s_tuser)
                KIND_REQUEST: begin
                    if (phase_reg != PH_IDLE) begin
                        decision = (flow_reg == in_flow) ? DEC_PENDING : DEC_BUSY;
                    end else if (!in_mode && cache_valid_reg &&
                                 cache_age_reg <= fresh_limit_reg) begin
                        decision   = DEC_CACHE;
                        flow_next  = in_flow;
                        phase_next = PH_REPLY;
                    end else begin
                        decision      = DEC_REMOTE;
                        flow_next     = in_flow;
                        wait_age_next = '0;
                        error_next    = '0;
                        phase_next    = PH_WAIT;
                    end
                end
                KIND_SAMPLE: begin
                    if (phase_reg == PH_WAIT && flow_reg == in_flow) begin
                        accepted = 1'b1;
                        mem_wr   = in_range;
                        if (s_tlast) begin
                            cache_age_next   = '0;
                            cache_valid_next = 1'b1;
                            phase_next       = PH_REPLY;
                        end
                    end
                end
                KIND_TICK: begin
                    wait_age_next  = wait_age_inc;
                    cache_age_next = cache_age_reg + 32'd1;
                    if (phase_reg == PH_WAIT && wait_age_inc >= resp_timeout_reg) begin
                        error_next = timeout_code_reg;
                        phase_next = PH_ERROR;
                        accepted   = 1'b1;
                    end
                end
                KIND_DONE: begin
                    if (phase_reg == PH_REPLY || phase_reg == PH_ERROR) begin
                        flow_next  = '0;
                        error_next = '0;
                        phase_next = PH_IDLE;
                        accepted   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // channel cache: memory plus per-entry written bits
    logic [15:0]             cache_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] ent_valid_reg;
    logic [15:0]             mem_q_reg;

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            cache_mem[in_addr] <= in_sample;
        end
        if (accept) begin
            mem_q_reg <= cache_mem[in_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
        end else if (mem_wr) begin
            ent_valid_reg[in_addr] <= 1'b1;
        end
    end

    // stage 1: result fields waiting on the memory read
    logic [1:0]  st1_decision_reg;
    logic        st1_accepted_reg;
    logic [1:0]  st1_phase_reg;
    logic [15:0] st1_flow_reg;
    logic [7:0]  st1_error_reg;
    logic        st1_range_reg;
    logic        st1_fwd_reg;
    logic [15:0] st1_fwd_data_reg;
    logic        st1_ent_valid_reg;
    logic [15:0] st1_cval;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_decision_reg  <= decision;
            st1_accepted_reg  <= accepted;
            st1_phase_reg     <= phase_next;
            st1_flow_reg      <= flow_next;
            st1_error_reg     <= error_next;
            st1_range_reg     <= in_range;
            st1_fwd_reg       <= mem_wr;
            st1_fwd_data_reg  <= in_sample;
            st1_ent_valid_reg <= ent_valid_reg[in_addr];
        end
    end

    always_comb begin
        if (!st1_range_reg) begin
            st1_cval = '0;
        end else if (st1_fwd_reg) begin
            st1_cval = st1_fwd_data_reg;
        end else if (st1_ent_valid_reg) begin
            st1_cval = mem_q_reg;
        end else begin
            st1_cval = '0;
        end
    end

    // output register
    logic [47:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (st1_adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            m_tdata_reg <= {3'b000, st1_cval, st1_error_reg, st1_flow_reg,
                            st1_phase_reg, st1_accepted_reg, st1_decision_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
